// ===== hw/rtl/tpfi_pkg.sv =====
package tpfi_pkg;

	// Field widths of the sample, result and register beats.
	localparam int TIME_W   = 32;
	localparam int TEMP_W   = 19;
	localparam int DRV_W    = 8;
	localparam int STATUS_W = 2;
	localparam int GAIN_W   = 40;
	localparam int TAU_W    = 34;
	localparam int THETA_W  = 33;

	// APB register file: five registers in 32-bit words at word addresses.
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// Temperature change and level arithmetic. Levels are kept in units of
	// 1/1000 millidegree, which needs 28 bits plus sign.
	localparam int DT_W  = TEMP_W + 1;
	localparam int LV_W  = 32;
	localparam int MAG_W = 30;

	localparam logic signed [LV_W-1:0] K_SCALE = 32'sd1000;
	localparam logic signed [LV_W-1:0] K_LOW   = 32'sd283;
	localparam logic signed [LV_W-1:0] K_HIGH  = 32'sd632;

	// Gain: dT * 255 * 65536 / (100 * dDrive).
	localparam int GSCALE_W = 24;
	localparam int PCT_W    = 7;
	localparam logic [GSCALE_W-1:0] GAIN_SCALE = 24'd16711680;
	localparam logic [PCT_W-1:0]    PCT_SCALE  = 7'd100;
	localparam int GNUM_W = DT_W + GSCALE_W;
	localparam int GDEN_W = DRV_W + PCT_W;

	// Shared restoring divider.
	localparam int DIV_NUM_W = MAG_W + TIME_W;
	localparam int DIV_DEN_W = MAG_W;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

	typedef struct packed {
		logic [TIME_W-1:0]        step_time;
		logic signed [TEMP_W-1:0] start_temperature;
		logic signed [TEMP_W-1:0] end_temperature;
		logic [DRV_W-1:0]         start_drive;
		logic [DRV_W-1:0]         end_drive;
	} tpfi_cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic prep;
		logic test;
		logic mul;
		logic div_start;
		logic div_gain;
		logic store;
		logic update;
		logic gain_prep;
		logic gain_store;
		logic tau_diff;
		logic tau_scale;
		logic emit;
		logic lvl;
	} tpfi_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic hit;
		logic last;
		logic div_busy;
		logic div_done;
		logic no_drive;
		logic res_valid;
	} tpfi_sts_t;

endpackage

// ===== hw/rtl/tpfi_if.sv =====
interface tpfi_sample_if;
	logic                               valid;
	logic                               ready;
	logic [tpfi_pkg::TIME_W-1:0]        sample_time;
	logic signed [tpfi_pkg::TEMP_W-1:0] sample_temperature;
	logic                               last_sample;

	modport source (output valid, sample_time, sample_temperature, last_sample, input ready);
	modport sink (input valid, sample_time, sample_temperature, last_sample, output ready);
endinterface

interface tpfi_result_if;
	logic                               valid;
	logic                               ready;
	logic [tpfi_pkg::STATUS_W-1:0]      status;
	logic signed [tpfi_pkg::GAIN_W-1:0] gain_q16;
	logic signed [tpfi_pkg::TAU_W-1:0]  time_constant;
	logic [tpfi_pkg::THETA_W-1:0]       dead_time;

	modport source (output valid, status, gain_q16, time_constant, dead_time, input ready);
	modport sink (input valid, status, gain_q16, time_constant, dead_time, output ready);
endinterface

// ===== hw/rtl/tpfi_regs.sv =====
module tpfi_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tpfi_pkg::ADDR_W-1:0]   paddr,
	input  logic [tpfi_pkg::DATA_W-1:0]   pwdata,
	output logic [tpfi_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output tpfi_pkg::tpfi_cfg_t           cfg
);
	import tpfi_pkg::*;

	typedef enum logic [2:0] {
		REG_STEP_TIME  = 3'd0,
		REG_START_TEMP = 3'd1,
		REG_END_TEMP   = 3'd2,
		REG_START_DRV  = 3'd3,
		REG_END_DRV    = 3'd4
	} reg_idx_t;

	tpfi_cfg_t cfg_q;
	logic [2:0] idx;
	logic       wr_en;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_time         <= '0;
			cfg_q.start_temperature <= '0;
			cfg_q.end_temperature   <= '0;
			cfg_q.start_drive       <= '0;
			cfg_q.end_drive         <= '1;
		end else if (wr_en) begin
			case (idx)
				REG_STEP_TIME:  cfg_q.step_time         <= pwdata[TIME_W-1:0];
				REG_START_TEMP: cfg_q.start_temperature <= pwdata[TEMP_W-1:0];
				REG_END_TEMP:   cfg_q.end_temperature   <= pwdata[TEMP_W-1:0];
				REG_START_DRV:  cfg_q.start_drive       <= pwdata[DRV_W-1:0];
				REG_END_DRV:    cfg_q.end_drive         <= pwdata[DRV_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_STEP_TIME:  prdata = DATA_W'(cfg_q.step_time);
			REG_START_TEMP: prdata = DATA_W'(cfg_q.start_temperature);
			REG_END_TEMP:   prdata = DATA_W'(cfg_q.end_temperature);
			REG_START_DRV:  prdata = DATA_W'(cfg_q.start_drive);
			REG_END_DRV:    prdata = DATA_W'(cfg_q.end_drive);
			default:        prdata = '0;
		endcase
	end

endmodule

// ===== hw/rtl/tpfi_div.sv =====
module tpfi_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [tpfi_pkg::DIV_NUM_W-1:0]   dividend,
	input  logic [tpfi_pkg::DIV_DEN_W-1:0]   divisor,
	output logic                             busy,
	output logic                             done,
	output logic [tpfi_pkg::DIV_NUM_W-1:0]   quotient
);
	import tpfi_pkg::*;

	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIV_DEN_W:0]   sh;
	logic [DIV_DEN_W:0]   trial;
	logic                 ge;
	logic [DIV_DEN_W-1:0] rem_next;

	// One quotient bit per cycle, most significant first.
	assign sh       = {rem_q, quo_q[DIV_NUM_W-1]};
	assign trial    = sh - {1'b0, den_q};
	assign ge       = sh >= {1'b0, den_q};
	assign rem_next = ge ? trial[DIV_DEN_W-1:0] : sh[DIV_DEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== hw/rtl/tpfi_dp.sv =====
module tpfi_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tpfi_pkg::tpfi_cfg_t                cfg,
	input  tpfi_pkg::tpfi_cmd_t                cmd,
	output tpfi_pkg::tpfi_sts_t                sts,
	input  logic [tpfi_pkg::TIME_W-1:0]        sample_time,
	input  logic signed [tpfi_pkg::TEMP_W-1:0] sample_temperature,
	input  logic                               last_sample,
	output logic                               res_valid,
	input  logic                               res_ready,
	output logic [tpfi_pkg::STATUS_W-1:0]      status,
	output logic signed [tpfi_pkg::GAIN_W-1:0] gain_q16,
	output logic signed [tpfi_pkg::TAU_W-1:0]  time_constant,
	output logic [tpfi_pkg::THETA_W-1:0]       dead_time
);
	import tpfi_pkg::*;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NO_DRIVE  = 2'd1,
		ST_NOT_FOUND = 2'd2
	} fit_status_t;

	// Current and previous sample, temperatures scaled by 1000.
	logic [TIME_W-1:0]      cur_time_q, prev_time_q;
	logic signed [LV_W-1:0] cur_scaled_q, prev_scaled_q;
	logic                   last_q, have_prev_q;

	// Crossing results.
	logic                   found_lo_q, found_hi_q;
	logic [TIME_W-1:0]      lo_time_q, hi_time_q;

	// Level test pipeline.
	logic signed [LV_W-1:0] level_q;
	logic                   elig_q, dt_pos_q, dt_neg_q;
	logic [MAG_W-1:0]       num_q, den_q;
	logic [TIME_W-1:0]      span_q;
	logic                   dir_q, hit_q;
	logic [DIV_NUM_W-1:0]   prod_q;

	// Gain and time constant.
	logic [GNUM_W-1:0]          gnum_q;
	logic [GDEN_W-1:0]          gden_q;
	logic                       gsign_q, no_drive_q;
	logic signed [GAIN_W-1:0]   gain_q;
	logic signed [TIME_W:0]     diff_q, tpre_q;
	logic signed [TAU_W-1:0]    tau_q;

	// Result register.
	logic                       res_valid_q;
	fit_status_t                res_status_q;
	logic signed [GAIN_W-1:0]   res_gain_q;
	logic signed [TAU_W-1:0]    res_tau_q;
	logic [THETA_W-1:0]         res_theta_q;

	// Divider hookup.
	logic [DIV_NUM_W-1:0] div_dividend, div_quo;
	logic [DIV_DEN_W-1:0] div_divisor;
	logic                 div_busy, div_done;

	// Combinational terms.
	logic signed [DT_W-1:0]     dtemp;
	logic signed [LV_W-1:0]     cur_scaled, level_k, level;
	logic                       elig;
	logic signed [LV_W-1:0]     diff_l, diff_d, num_full, den_full;
	logic                       hit_up, hit_dn, dir;
	logic [TIME_W-1:0]          span, off, t_new;
	logic [DIV_NUM_W-1:0]       prod;
	logic signed [DRV_W:0]      ddrive;
	logic [DT_W-1:0]            dmag;
	logic [DRV_W:0]             ddmag;
	logic [GAIN_W-1:0]          gq;
	logic signed [TIME_W:0]     hi_x, lo_x, step_x;
	logic signed [TAU_W:0]      x3, x3r, theta_full;
	logic [THETA_W-1:0]         theta;

	assign dtemp      = DT_W'(cfg.end_temperature) - DT_W'(cfg.start_temperature);
	assign cur_scaled = LV_W'(sample_temperature) * K_SCALE;
	assign level_k    = cmd.lvl ? K_HIGH : K_LOW;
	assign level      = LV_W'(cfg.start_temperature) * K_SCALE + LV_W'(dtemp) * level_k;
	assign elig       = have_prev_q && (cur_time_q >= cfg.step_time) &&
	                    !(cmd.lvl ? found_hi_q : found_lo_q);

	// The pair crosses the level in the direction of the temperature change.
	assign diff_l   = level_q - prev_scaled_q;
	assign diff_d   = cur_scaled_q - prev_scaled_q;
	assign num_full = diff_l[LV_W-1] ? -diff_l : diff_l;
	assign den_full = diff_d[LV_W-1] ? -diff_d : diff_d;
	assign hit_up   = dt_pos_q && (prev_scaled_q < level_q) && (cur_scaled_q >= level_q);
	assign hit_dn   = dt_neg_q && (prev_scaled_q > level_q) && (cur_scaled_q <= level_q);
	assign dir      = cur_time_q >= prev_time_q;
	assign span     = dir ? cur_time_q - prev_time_q : prev_time_q - cur_time_q;

	assign prod = num_q * span_q;

	assign off   = div_quo[TIME_W-1:0];
	assign t_new = dir_q ? prev_time_q + off : prev_time_q - off;

	assign ddrive = $signed({1'b0, cfg.end_drive}) - $signed({1'b0, cfg.start_drive});
	assign dmag   = dtemp[DT_W-1] ? DT_W'(-dtemp) : DT_W'(dtemp);
	assign ddmag  = ddrive[DRV_W] ? (DRV_W+1)'(-ddrive) : (DRV_W+1)'(ddrive);
	assign gq     = div_quo[GAIN_W-1:0];

	assign hi_x   = $signed({1'b0, hi_time_q});
	assign lo_x   = $signed({1'b0, lo_time_q});
	assign step_x = $signed({1'b0, cfg.step_time});

	// tau = 3 * diff / 2, rounded toward zero.
	assign x3  = (TAU_W+1)'(diff_q) + ((TAU_W+1)'(diff_q) <<< 1);
	assign x3r = x3 + {{TAU_W{1'b0}}, x3[TAU_W]};

	// Dead time clamped into [0, 2^33 - 1].
	assign theta_full = (TAU_W+1)'(tpre_q) - (TAU_W+1)'(tau_q);
	always_comb begin
		if (theta_full[TAU_W])
			theta = '0;
		else if (|theta_full[TAU_W-1:THETA_W])
			theta = '1;
		else
			theta = theta_full[THETA_W-1:0];
	end

	assign div_dividend = cmd.div_gain ? DIV_NUM_W'(gnum_q) : prod_q;
	assign div_divisor  = cmd.div_gain ? DIV_DEN_W'(gden_q) : den_q;

	tpfi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Control flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			found_lo_q  <= 1'b0;
			found_hi_q  <= 1'b0;
			hit_q       <= 1'b0;
			last_q      <= 1'b0;
			no_drive_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.load)
				last_q <= last_sample;
			if (cmd.test)
				hit_q <= elig_q && (hit_up || hit_dn);
			if (cmd.gain_prep)
				no_drive_q <= (ddrive == '0);
			if (cmd.store) begin
				if (cmd.lvl)
					found_hi_q <= 1'b1;
				else
					found_lo_q <= 1'b1;
			end
			if (cmd.update)
				have_prev_q <= 1'b1;
			if (cmd.emit) begin
				have_prev_q <= 1'b0;
				found_lo_q  <= 1'b0;
				found_hi_q  <= 1'b0;
			end
			if (cmd.emit)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_time_q   <= sample_time;
			cur_scaled_q <= cur_scaled;
		end
		if (cmd.update) begin
			prev_time_q   <= cur_time_q;
			prev_scaled_q <= cur_scaled_q;
		end
		if (cmd.prep) begin
			level_q  <= level;
			elig_q   <= elig;
			dt_pos_q <= !dtemp[DT_W-1] && (dtemp != '0);
			dt_neg_q <= dtemp[DT_W-1];
		end
		if (cmd.test) begin
			num_q  <= num_full[MAG_W-1:0];
			den_q  <= den_full[MAG_W-1:0];
			span_q <= span;
			dir_q  <= dir;
		end
		if (cmd.mul)
			prod_q <= prod;
		if (cmd.store) begin
			if (cmd.lvl)
				hi_time_q <= t_new;
			else
				lo_time_q <= t_new;
		end
		if (cmd.gain_prep) begin
			gnum_q  <= dmag * GAIN_SCALE;
			gden_q  <= ddmag[DRV_W-1:0] * PCT_SCALE;
			gsign_q <= dtemp[DT_W-1] ^ ddrive[DRV_W];
		end
		if (cmd.gain_store)
			gain_q <= gsign_q ? -$signed(gq) : $signed(gq);
		if (cmd.tau_diff) begin
			diff_q <= hi_x - lo_x;
			tpre_q <= hi_x - step_x;
		end
		if (cmd.tau_scale)
			tau_q <= x3r[TAU_W:1];
		if (cmd.emit) begin
			if (no_drive_q) begin
				res_status_q <= ST_NO_DRIVE;
				res_gain_q   <= '0;
				res_tau_q    <= '0;
				res_theta_q  <= '0;
			end else if (found_lo_q && found_hi_q) begin
				res_status_q <= ST_OK;
				res_gain_q   <= gain_q;
				res_tau_q    <= tau_q;
				res_theta_q  <= theta;
			end else begin
				res_status_q <= ST_NOT_FOUND;
				res_gain_q   <= gain_q;
				res_tau_q    <= '0;
				res_theta_q  <= '0;
			end
		end
	end

	assign sts.hit       = hit_q;
	assign sts.last      = last_q;
	assign sts.div_busy  = div_busy;
	assign sts.div_done  = div_done;
	assign sts.no_drive  = no_drive_q;
	assign sts.res_valid = res_valid_q;

	assign res_valid     = res_valid_q;
	assign status        = res_status_q;
	assign gain_q16      = res_gain_q;
	assign time_constant = res_tau_q;
	assign dead_time     = res_theta_q;

	// A detected crossing lies within the pair, possibly on its later sample, so the fraction is at most one.
	a_hit_fraction: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul |-> (den_q != '0) && (num_q <= den_q))
		else $error("crossing numerator exceeds its span");

	// The interpolated offset never leaves the interval between the two samples.
	a_offset_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |-> (div_quo[DIV_NUM_W-1:TIME_W] == '0) && (off <= span_q))
		else $error("crossing offset outside the sample interval");

	// Producing a result clears the record state for the next run.
	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> res_valid_q && !have_prev_q && !found_lo_q && !found_hi_q)
		else $error("record state not cleared after result");

endmodule

// ===== hw/rtl/tpfi_ctrl.sv =====
module tpfi_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_ready,
	input  tpfi_pkg::tpfi_sts_t sts,
	output tpfi_pkg::tpfi_cmd_t cmd
);
	import tpfi_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP,
		S_TEST,
		S_CHOOSE,
		S_DSTART,
		S_DWAIT,
		S_UPDATE,
		S_GPREP,
		S_GSTART,
		S_GWAIT,
		S_TDIFF,
		S_TSCALE,
		S_EMIT
	} state_t;

	state_t state_q;
	logic   lvl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lvl_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (sample_valid) begin
						state_q <= S_PREP;
						lvl_q   <= 1'b0;
					end
				end
				S_PREP:   state_q <= S_TEST;
				S_TEST:   state_q <= S_CHOOSE;
				S_CHOOSE: begin
					if (sts.hit) begin
						state_q <= S_DSTART;
					end else if (lvl_q) begin
						state_q <= S_UPDATE;
					end else begin
						lvl_q   <= 1'b1;
						state_q <= S_PREP;
					end
				end
				S_DSTART: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (sts.div_done) begin
						if (lvl_q) begin
							state_q <= S_UPDATE;
						end else begin
							lvl_q   <= 1'b1;
							state_q <= S_PREP;
						end
					end
				end
				S_UPDATE: state_q <= sts.last ? S_GPREP : S_IDLE;
				S_GPREP:  state_q <= S_GSTART;
				S_GSTART: state_q <= sts.no_drive ? S_TDIFF : S_GWAIT;
				S_GWAIT: begin
					if (sts.div_done)
						state_q <= S_TDIFF;
				end
				S_TDIFF:  state_q <= S_TSCALE;
				S_TSCALE: state_q <= S_EMIT;
				S_EMIT: begin
					if (!sts.res_valid)
						state_q <= S_IDLE;
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd     = '0;
		cmd.lvl = lvl_q;
		case (state_q)
			S_IDLE:   cmd.load = sample_valid;
			S_PREP:   cmd.prep = 1'b1;
			S_TEST:   cmd.test = 1'b1;
			S_CHOOSE: cmd.mul = sts.hit;
			S_DSTART: cmd.div_start = 1'b1;
			S_DWAIT:  cmd.store = sts.div_done;
			S_UPDATE: cmd.update = 1'b1;
			S_GPREP:  cmd.gain_prep = 1'b1;
			S_GSTART: begin
				cmd.div_start = !sts.no_drive;
				cmd.div_gain  = 1'b1;
			end
			S_GWAIT: begin
				cmd.div_gain   = 1'b1;
				cmd.gain_store = sts.div_done;
			end
			S_TDIFF:  cmd.tau_diff = 1'b1;
			S_TSCALE: cmd.tau_scale = 1'b1;
			S_EMIT:   cmd.emit = !sts.res_valid;
			default:  cmd.lvl = lvl_q;
		endcase
	end

	assign sample_ready = (state_q == S_IDLE);

	// Starting a division always finds the shared divider free and sets it busy.
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy ##1 sts.div_busy)
		else $error("divider started while busy or did not start");

	// A finished division is only ever seen while the controller waits for it.
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == S_DWAIT || state_q == S_GWAIT))
		else $error("divider finished outside a wait state");

	// A result is written only into an empty output register.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !sts.res_valid)
		else $error("result overwrote a pending result");

endmodule

// ===== hw/rtl/two_point_fopdt_identifier_top.sv =====
// Two-point step-response identifier for a first-order-plus-dead-time plant.
// Program step_time, start/end temperature and start/end drive over APB
// (word registers at byte addresses 0, 4, 8, 12 and 16) while the block is
// idle, then stream the record's (time, temperature) samples as beats on
// sample_ch with last_sample set on the final one. The block finds the
// first 28.3% and 63.2% crossings on segments ending at or after the step
// time and, on the final sample, puts one beat on result_ch: status, gain
// in signed Q24.16 millidegrees per percent duty, tau = 1.5 * (t63 - t28)
// and the dead time clamped at zero. Its crossing and previous-sample state
// then clears for the next record; registers keep their values.
//
// Sequencing: items are handled one at a time by a controller that steps a
// datapath; a new sample is accepted only once the last one is through.
// Each sample is tested against both levels, and each crossing found adds
// a run of the shared 62-step restoring divider that interpolates the
// crossing time. The final sample adds the gain division and the tau and
// dead time arithmetic, plus any wait for the previous result to be taken.
// The result sits in an output register, so the next record's samples are
// accepted while it waits.
module two_point_fopdt_identifier_top (
	input  logic                          clk,
	input  logic                          arst_n,
	tpfi_sample_if.sink                   sample_ch,
	tpfi_result_if.source                 result_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tpfi_pkg::ADDR_W-1:0]   paddr,
	input  logic [tpfi_pkg::DATA_W-1:0]   pwdata,
	output logic [tpfi_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import tpfi_pkg::*;

	tpfi_cfg_t cfg;
	tpfi_cmd_t cmd;
	tpfi_sts_t sts;

	// Configuration registers.
	tpfi_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The controller sequences each sample through the level tests, the
	// interpolation divisions and, on the last sample, the result.
	tpfi_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_ch.valid),
		.sample_ready (sample_ch.ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	// The datapath holds the record state, the shared divider and the
	// output register that drives result_ch.
	tpfi_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg                (cfg),
		.cmd                (cmd),
		.sts                (sts),
		.sample_time        (sample_ch.sample_time),
		.sample_temperature (sample_ch.sample_temperature),
		.last_sample        (sample_ch.last_sample),
		.res_valid          (result_ch.valid),
		.res_ready          (result_ch.ready),
		.status             (result_ch.status),
		.gain_q16           (result_ch.gain_q16),
		.time_constant      (result_ch.time_constant),
		.dead_time          (result_ch.dead_time)
	);

endmodule

// ===== verif/testbench.sv =====
module testbench;
	import tpfi_pkg::*;

	// Result status codes of the identifier.
	typedef enum logic [STATUS_W-1:0] {
		FIT_OK          = 2'd0,
		FIT_NO_DRIVE    = 2'd1,
		FIT_NO_CROSSING = 2'd2
	} fit_status_e;

	// Register indexes; the byte address is four times the index.
	typedef enum logic [2:0] {
		REG_STEP_TIME   = 3'd0,
		REG_START_TEMP  = 3'd1,
		REG_END_TEMP    = 3'd2,
		REG_START_DRIVE = 3'd3,
		REG_END_DRIVE   = 3'd4
	} plant_reg_e;

	typedef struct {
		fit_status_e              status;
		logic signed [GAIN_W-1:0] gain;
		logic signed [TAU_W-1:0]  tau;
		logic [THETA_W-1:0]       theta;
	} fit_t;

	// The block handles one sample at a time; even the slowest sample (two
	// crossings plus the final arithmetic) ends within this many quiet
	// cycles after the last result, which leave it idle.
	localparam int SETTLE_CYCLES  = 250;
	// The longest deliberate result hold-off is HOLD_OFF; no correct run
	// goes anywhere near this many cycles without a beat on either side.
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_OFF       = 1500;

	logic clk = 1'b0;
	logic arst_n;

	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	tpfi_sample_if sample_ch();
	tpfi_result_if result_ch();

	two_point_fopdt_identifier_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #6 clk = ~clk;

	// Our own copy of the plant registers, updated on every APB write.
	logic [TIME_W-1:0]        cfg_step_time   = '0;
	logic signed [TEMP_W-1:0] cfg_start_temp  = '0;
	logic signed [TEMP_W-1:0] cfg_end_temp    = '0;
	logic [DRV_W-1:0]         cfg_start_drive = '0;
	logic [DRV_W-1:0]         cfg_end_drive   = 8'd255;

	// Per-record tracking state: the previous sample and both crossings.
	logic [TIME_W-1:0]        prev_time  = '0;
	logic signed [TEMP_W-1:0] prev_temp  = '0;
	logic                     have_prev  = 1'b0;
	logic                     found_low  = 1'b0;
	logic [TIME_W-1:0]        low_time   = '0;
	logic                     found_high = 1'b0;
	logic [TIME_W-1:0]        high_time  = '0;

	fit_t        expected_fits[$];
	int unsigned mismatches      = 0;
	int unsigned samples_sent    = 0;
	int unsigned hold_off_cycles = 0;
	int unsigned stuck_cycles    = 0;
	logic        idling_on       = 1'b1;

	// Tests one level against the segment from the previous sample to the
	// current one. Levels and temperatures are compared in units of 1/1000
	// millidegree. On the first crossing the time is interpolated along the
	// segment with truncation, walking backward when the timestamps fall.
	function automatic void interpolate_crossing(input longint level, input longint dtemp,
			input logic [TIME_W-1:0] t1, input longint y1,
			input logic [TIME_W-1:0] t2, input longint y2,
			inout logic found, inout logic [TIME_W-1:0] when);
		longint          s1;
		longint          s2;
		longint unsigned num;
		longint unsigned den;
		longint unsigned span;
		longint unsigned off;
		logic            hit;
		s1 = 1000 * y1;
		s2 = 1000 * y2;
		if (found)
			return;
		hit = (dtemp > 0 && s1 < level && s2 >= level) ||
		      (dtemp < 0 && s1 > level && s2 <= level);
		if (!hit)
			return;
		num  = (level > s1) ? level - s1 : s1 - level;
		den  = (s2 > s1) ? s2 - s1 : s1 - s2;
		span = (t2 >= t1) ? t2 - t1 : t1 - t2;
		off  = num * span / den;
		when = (t2 >= t1) ? t1 + off[TIME_W-1:0] : t1 - off[TIME_W-1:0];
		found = 1'b1;
	endfunction

	// Advances the identifier state by one accepted sample and, on the final
	// sample of a record, queues the fit that the block must report.
	function automatic void fit_step_response(input logic [TIME_W-1:0] t,
			input logic signed [TEMP_W-1:0] y, input logic last);
		longint dtemp;
		longint ddrive;
		longint base;
		longint gain;
		longint lo;
		longint hi;
		longint step_ms;
		longint tau;
		longint theta;
		fit_t   fit;
		dtemp = cfg_end_temp;
		dtemp -= cfg_start_temp;
		ddrive = cfg_end_drive;
		ddrive -= cfg_start_drive;
		if (have_prev && t >= cfg_step_time) begin
			base = cfg_start_temp;
			base = base * 1000;
			interpolate_crossing(base + 283 * dtemp, dtemp, prev_time, prev_temp, t, y,
				found_low, low_time);
			interpolate_crossing(base + 632 * dtemp, dtemp, prev_time, prev_temp, t, y,
				found_high, high_time);
		end
		prev_time = t;
		prev_temp = y;
		have_prev = 1'b1;
		if (!last)
			return;

		fit.status = FIT_OK;
		fit.gain   = '0;
		fit.tau    = '0;
		fit.theta  = '0;
		if (ddrive == 0) begin
			fit.status = FIT_NO_DRIVE;
		end else begin
			gain = dtemp * 255 * 65536 / (100 * ddrive);
			fit.gain = gain[GAIN_W-1:0];
			if (found_low && found_high) begin
				lo = low_time;
				hi = high_time;
				step_ms = cfg_step_time;
				tau = 3 * (hi - lo) / 2;
				theta = hi - step_ms - tau;
				if (theta < 0)
					theta = 0;
				if (theta > 64'sh1_FFFF_FFFF)
					theta = 64'sh1_FFFF_FFFF;
				fit.tau   = tau[TAU_W-1:0];
				fit.theta = theta[THETA_W-1:0];
			end else begin
				fit.status = FIT_NO_CROSSING;
			end
		end
		expected_fits.push_back(fit);

		// A new record starts from scratch; the registers are kept.
		prev_time  = '0;
		prev_temp  = '0;
		have_prev  = 1'b0;
		found_low  = 1'b0;
		low_time   = '0;
		found_high = 1'b0;
		high_time  = '0;
	endfunction

	// Result side: compares every accepted result beat against the oldest
	// queued fit, then decides ready for the next edge. A pending hold-off
	// keeps ready low until hold_off_cycles has counted down to zero.
	initial begin
		fit_t want;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				if (expected_fits.size() == 0) begin
					$error("result beat with no fit expected");
					mismatches++;
				end else begin
					want = expected_fits.pop_front();
					if (result_ch.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result_ch.status);
						mismatches++;
					end
					if (result_ch.gain_q16 !== want.gain) begin
						$error("gain_q16: expected %0d, got %0d", want.gain, result_ch.gain_q16);
						mismatches++;
					end
					if (result_ch.time_constant !== want.tau) begin
						$error("time_constant: expected %0d, got %0d", want.tau,
							result_ch.time_constant);
						mismatches++;
					end
					if (result_ch.dead_time !== want.theta) begin
						$error("dead_time: expected %0d, got %0d", want.theta,
							result_ch.dead_time);
						mismatches++;
					end
				end
			end
			if (hold_off_cycles > 0) begin
				result_ch.ready <= 1'b0;
				hold_off_cycles--;
			end else begin
				result_ch.ready <= !idling_on || ($urandom_range(99) >= 27);
			end
		end
	end

	// The watchdog ends the run when neither channel has moved a beat for
	// far longer than any correct run can take.
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// Offers one sample beat, after a random number of idle cycles, and
	// waits until the block takes it. The sample is then fed to the
	// predictor. valid is left high so back-to-back beats need no gap.
	task automatic send_sample(input logic [TIME_W-1:0] t, input logic signed [TEMP_W-1:0] y,
			input logic last);
		while (idling_on && $urandom_range(99) < 27) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid              <= 1'b1;
		sample_ch.sample_time        <= t;
		sample_ch.sample_temperature <= y;
		sample_ch.last_sample        <= last;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		fit_step_response(t, y, last);
		samples_sent++;
	endtask

	// Stops offering samples and waits until every queued fit has come
	// back, then lets the block finish any sample that makes no result.
	task automatic quiesce();
		sample_ch.valid <= 1'b0;
		while (expected_fits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One APB write followed directly by a read of the same register. Only
	// the register's own bits of the read data are compared.
	task automatic program_reg(input plant_reg_e idx, input logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] width_mask;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			REG_STEP_TIME: begin
				cfg_step_time = value;
				width_mask = 32'hFFFF_FFFF;
			end
			REG_START_TEMP: begin
				cfg_start_temp = value[TEMP_W-1:0];
				width_mask = 32'h0007_FFFF;
			end
			REG_END_TEMP: begin
				cfg_end_temp = value[TEMP_W-1:0];
				width_mask = 32'h0007_FFFF;
			end
			REG_START_DRIVE: begin
				cfg_start_drive = value[DRV_W-1:0];
				width_mask = 32'h0000_00FF;
			end
			default: begin
				cfg_end_drive = value[DRV_W-1:0];
				width_mask = 32'h0000_00FF;
			end
		endcase
		// Read back: a fresh setup phase follows the write's access phase.
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if ((prdata & width_mask) !== (value & width_mask)) begin
			$error("prdata: expected %0h, got %0h", value & width_mask, prdata & width_mask);
			mismatches++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Registers are only touched once the block has gone quiet.
	task automatic setup_plant(input logic [TIME_W-1:0] step_ms, input int start_temp,
			input int end_temp, input int start_drive, input int end_drive);
		quiesce();
		program_reg(REG_STEP_TIME, step_ms);
		program_reg(REG_START_TEMP, 32'(start_temp));
		program_reg(REG_END_TEMP, 32'(end_temp));
		program_reg(REG_START_DRIVE, 32'(start_drive));
		program_reg(REG_END_DRIVE, 32'(end_drive));
	endtask

	function automatic int rand_temp();
		case ($urandom_range(7))
			0: return -200000;
			1: return 200000;
			2: return 0;
			default: return int'($urandom_range(400000)) - 200000;
		endcase
	endfunction

	function automatic int rand_drive();
		case ($urandom_range(5))
			0: return 0;
			1: return 255;
			default: return int'($urandom_range(255));
		endcase
	endfunction

	// Random settings, with register extremes (temperatures at +/-200000), equal
	// drives and a zero temperature change showing up now and then.
	task automatic setup_random_plant();
		logic [TIME_W-1:0] step_ms;
		int                t0;
		int                d0;
		case ($urandom_range(9))
			0: step_ms = '0;
			1: step_ms = 32'hFFFF_FFFF;
			2: step_ms = $urandom();
			default: step_ms = $urandom_range(100000);
		endcase
		t0 = rand_temp();
		d0 = rand_drive();
		setup_plant(step_ms, t0, ($urandom_range(9) == 0) ? t0 : rand_temp(),
			d0, ($urandom_range(7) == 0) ? d0 : rand_drive());
	endtask

	// A plausible step response for the current registers: a few samples
	// before the step, a dead stretch at the start temperature, a linear
	// ramp to the end temperature and the settled tail. Some records carry
	// measurement noise and some repeat a timestamp.
	task automatic send_step_record(input int n);
		longint            y0;
		longint            dtemp;
		longint            y;
		logic [TIME_W-1:0] t;
		int                dt;
		int                pre;
		int                dead;
		int                rise;
		int                k;
		logic              noisy;
		y0    = cfg_start_temp;
		dtemp = cfg_end_temp;
		dtemp -= cfg_start_temp;
		dt    = $urandom_range(1, 2000);
		pre   = $urandom_range(0, 2);
		dead  = $urandom_range(0, 3);
		rise  = $urandom_range(1, n);
		noisy = ($urandom_range(3) == 0);
		t = cfg_step_time - pre * dt;
		for (int i = 0; i < n; i++) begin
			k = i - pre - dead;
			if (k <= 0)
				y = y0;
			else if (k >= rise)
				y = y0 + dtemp;
			else
				y = y0 + dtemp * k / rise;
			if (noisy)
				y += int'($urandom_range(1000)) - 500;
			if (y > 200000)
				y = 200000;
			if (y < -200000)
				y = -200000;
			send_sample(t, y[TEMP_W-1:0], i == n - 1);
			if ($urandom_range(15) != 0)
				t += dt;
		end
	endtask

	// Broken records: arbitrary timestamps, often falling, and arbitrary
	// temperatures.
	task automatic send_noise_record(input int n);
		for (int i = 0; i < n; i++)
			send_sample($urandom(), 19'(int'($urandom_range(400000)) - 200000), i == n - 1);
	endtask

	// A clean rising response. The first two samples lie before the step
	// and jump across both levels; they must only serve as the previous
	// sample and never count as crossings.
	task automatic test_rising_record();
		setup_plant(1000, 20000, 60000, 0, 255);
		send_sample(0, 20000, 1'b0);
		send_sample(500, 60000, 1'b0);
		send_sample(1000, 20000, 1'b0);
		send_sample(1500, 25000, 1'b0);
		send_sample(2000, 35000, 1'b0);
		send_sample(2500, 50000, 1'b0);
		send_sample(3000, 58000, 1'b0);
		send_sample(3500, 60000, 1'b1);
	endtask

	// A falling response over the full temperature range with the drive
	// going from full to zero, near the top of the time range.
	task automatic test_falling_record();
		setup_plant(32'hFFFF_0000, 200000, -200000, 255, 0);
		send_sample(32'hFFFF_0000, 200000, 1'b0);
		send_sample(32'hFFFF_4000, 100000, 1'b0);
		send_sample(32'hFFFF_8000, -50000, 1'b0);
		send_sample(32'hFFFF_C000, -150000, 1'b0);
		send_sample(32'hFFFF_FFFF, -200000, 1'b1);
	endtask

	// Equal drives give no gain at all, whatever the temperatures do.
	task automatic test_no_drive_change();
		setup_plant(0, -200000, 200000, 128, 128);
		send_sample(0, -200000, 1'b0);
		send_sample(100, 200000, 1'b1);
	endtask

	// With no temperature change there is nothing to cross. A record made
	// of its final sample alone has no segment to test either.
	task automatic test_flat_temperature();
		setup_plant(0, 5000, 5000, 0, 1);
		send_sample(10, 5000, 1'b0);
		send_sample(20, 9000, 1'b1);
		send_sample(30, -7, 1'b1);
	endtask

	// The low crossing falls exactly at time zero, which must still count
	// as found. The high crossing follows so soon that the dead time comes
	// out negative and is clamped. A one-count drive step gives the
	// largest gain.
	task automatic test_crossing_at_time_zero();
		setup_plant(0, -200000, 200000, 254, 255);
		send_sample(0, -200000, 1'b0);
		send_sample(0, 0, 1'b0);
		send_sample(1000, 52800, 1'b1);
	endtask

	// Timestamps running backward across the whole time range: the low
	// crossing lands at the top of the range and the high one at zero, so
	// tau is at its most negative and the dead time at its largest.
	task automatic test_reversed_timestamps();
		setup_plant(0, 0, 100000, 0, 255);
		send_sample(32'hFFFF_FFFF, 0, 1'b0);
		send_sample(32'hFFFF_FFFF, 50000, 1'b0);
		send_sample(0, 63200, 1'b1);
	endtask

	// The result side holds off for a long time while samples keep coming
	// with no gaps, so the output register fills and the block must stall
	// its sample input until the first result is finally taken.
	task automatic test_output_backpressure();
		setup_plant(2000, -50000, 120000, 40, 200);
		idling_on = 1'b0;
		hold_off_cycles = HOLD_OFF;
		repeat (5) send_step_record(3);
		idling_on = 1'b1;
		quiesce();
	endtask

	// Mostly well-formed step responses with random content, with a tenth
	// of the records noise; the registers change every few records.
	task automatic test_random_records(input int unsigned target);
		int unsigned records;
		records = 0;
		while (samples_sent < target) begin
			if (records % 6 == 0)
				setup_random_plant();
			if ($urandom_range(9) == 0)
				send_noise_record($urandom_range(1, 6));
			else
				send_step_record($urandom_range(3, 14));
			records++;
		end
	endtask

	// A long stretch with neither side ever idling.
	task automatic test_steady_stream(input int unsigned target);
		setup_random_plant();
		idling_on = 1'b0;
		while (samples_sent < target)
			send_step_record($urandom_range(3, 14));
		quiesce();
		idling_on = 1'b1;
	endtask

	initial begin
		arst_n                       <= 1'b0;
		psel                         <= 1'b0;
		penable                      <= 1'b0;
		pwrite                       <= 1'b0;
		paddr                        <= '0;
		pwdata                       <= '0;
		sample_ch.valid              <= 1'b0;
		sample_ch.sample_time        <= '0;
		sample_ch.sample_temperature <= '0;
		sample_ch.last_sample        <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_rising_record();
		test_falling_record();
		test_no_drive_change();
		test_flat_temperature();
		test_crossing_at_time_zero();
		test_reversed_timestamps();
		test_output_backpressure();
		test_random_records(470);
		test_steady_stream(620);
		quiesce();

		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
